// ----- rtl/core/bsrt_pkg.sv -----
// bsrt_pkg: shared types for the byte array sorter
// used by bsrt_cell and byte_array_sorter, no dependencies
package bsrt_pkg;

  typedef logic [7:0] byte_t;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic  ins_en;     // insert new_value into the sorted row
    logic  pop_en;     // shift the row one place towards cell 0
    byte_t new_value;  // element being inserted
  } cell_ctrl_t;

endpackage

// ----- rtl/core/byte_array_sorter.sv -----
// byte_array_sorter: top level, a row of insertion cells that keeps a batch sorted
// depends on bsrt_pkg and bsrt_cell
//
// Use: bytes of a batch arrive on the in_ stream, one per beat, in_tlast on the
// final one. Each beat is inserted in sorted place along a row of MAX_ITEMS
// cells in the cycle it is accepted. Beats arriving while the row is full
// are dropped and the batch is flagged. On the beat with in_tlast the block
// stops taking input (in_tready low) and drains the row from cell 0, one
// ascending byte per cycle while out_tready is high, on the out_ stream;
// out_tlast marks the final byte and out_tuser carries the overflow flag on
// every byte of the batch. After the tlast beat the state register turns to
// drain and cell 0 is then popped into the output register, and in_tready
// rises again as the final byte enters the output register. A stalled
// receiver simply holds the output register and pauses the drain.
// Synchronous reset empties the row and clears the flag; no clearing pass
// is needed.
module byte_array_sorter
  import bsrt_pkg::*;
#(
  parameter int MAX_ITEMS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] value
  input  logic       in_tlast,   // last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] sorted_value
  output logic       out_tlast,  // last_out
  output logic       out_tuser   // [0] overflowed
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  byte_t            out_data_r;
  logic             out_last_r, out_user_r;

  cell_ctrl_t       ctrl;
  byte_t            vals [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] gts;
  logic [MAX_ITEMS-1:0] occ;

  logic in_acc, full, pop;

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign full      = (count_r == CNT_MAX);
  assign pop       = (state_r == ST_DRAIN) && (!out_valid_r || out_tready);

  assign ctrl.ins_en    = in_acc && !full;
  assign ctrl.pop_en    = pop;
  assign ctrl.new_value = in_tdata;

  // row of cells, cell 0 holds the smallest element
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    byte_t lv, rv;
    logic  lg;
    assign occ[i] = (count_r > CNT_W'(i));
    if (i == 0) begin : g_first
      assign lv = in_tdata;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = vals[i-1];
      assign lg = gts[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_end
      assign rv = vals[i];
    end else begin : g_inner
      assign rv = vals[i+1];
    end
    bsrt_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occupied (occ[i]),
      .left_val (lv),
      .left_gt  (lg),
      .right_val(rv),
      .val      (vals[i]),
      .gt       (gts[i])
    );
  end

  // load and drain control
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_ONE;
          end
          if (in_tlast) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (pop) begin
          out_valid_nxt = 1'b1;
          count_nxt     = count_r - CNT_ONE;
          if (count_r == CNT_ONE) begin
            state_nxt = ST_LOAD;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register, loaded from cell 0 on each pop
  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= vals[0];
      out_last_r <= (count_r == CNT_ONE);
      out_user_r <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  // checks on the row control
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("element count above capacity");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (count_r != '0))
    else $error("draining an empty row");

  a_final_pop_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && count_r == CNT_ONE) |=> (in_tready && out_tvalid && out_tlast))
    else $error("final beat of batch not marked or input not reopened");

  a_last_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && state_nxt == ST_LOAD) |=> !ovf_r)
    else $error("overflow flag kept past end of batch");

endmodule

// ----- rtl/core/bsrt_cell.sv -----
// bsrt_cell: one place of the sorted row, holds a single byte
// depends on bsrt_pkg for byte_t and cell_ctrl_t
module bsrt_cell
  import bsrt_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,   // this place holds an element
  input  byte_t      left_val,   // value of the neighbour nearer cell 0
  input  logic       left_gt,    // neighbour nearer cell 0 is empty or above new_value
  input  byte_t      right_val,  // value of the neighbour further from cell 0
  output byte_t      val,
  output logic       gt          // this place is empty or above new_value
);

  byte_t val_r, val_nxt;

  // empty places count as larger than any byte
  assign gt  = !occupied || (val_r > ctrl.new_value);
  assign val = val_r;

  // insert: make room by taking the left value, or take the new element; pop: take the right value
  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins_en && gt) begin
      val_nxt = left_gt ? left_val : ctrl.new_value;
    end else if (ctrl.pop_en) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
